// ===== rtl/arp_cache_engine_macros.svh =====
// Assertion macros shared by the ARP cache RTL.
// Relies on clk_i and rst_ni being present in the module that uses them.
`ifndef ARP_CACHE_ENGINE_MACROS_SVH
`define ARP_CACHE_ENGINE_MACROS_SVH

// same-cycle implication
`define ARPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/arpc_pkg.sv =====
// Shared types and constants of the ARP cache engine.
// No dependencies; imported by every ARP cache module.
`default_nettype none
package arpc_pkg;

  localparam int unsigned DefEntries = 32;
  localparam int unsigned IpW        = 32;
  localparam int unsigned MacW       = 48;
  localparam int unsigned TtlW       = 11;
  localparam int unsigned ExpW       = 6;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [IpW-1:0]  BcastIp    = '1;
  localparam logic [ExpW-1:0] ExpMax     = '1;
  localparam logic [TtlW-1:0] PendTtlRst = 11'd20;
  localparam logic [TtlW-1:0] EntTtlRst  = 11'd1200;

  typedef enum logic [1:0] {
    CMD_RESOLVE      = 2'd0,
    CMD_LEARN_ARP    = 2'd1,
    CMD_LEARN_DIRECT = 2'd2,
    CMD_TICK         = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_BCAST  = 3'd1,
    ST_REQ    = 3'd2,
    ST_NOTUS  = 3'd3,
    ST_UPD    = 3'd4,
    ST_INS    = 3'd5,
    ST_TICKED = 3'd6,
    ST_PEND   = 3'd7
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MY_IP       = 3'd0,
    CFG_NET_MASK    = 3'd1,
    CFG_MY_NET      = 3'd2,
    CFG_GATE_IP     = 3'd3,
    CFG_PENDING_TTL = 3'd4,
    CFG_ENTRY_TTL   = 3'd5
  } cfg_e;

  typedef enum logic [1:0] {
    MAC_ZERO = 2'd0,
    MAC_ONES = 2'd1,
    MAC_MEM  = 2'd2
  } mac_sel_e;

  typedef enum logic [2:0] {
    FSM_IDLE   = 3'd0,
    FSM_SCAN   = 3'd1,
    FSM_DRAIN  = 3'd2,
    FSM_DECIDE = 3'd3,
    FSM_FINISH = 3'd4
  } fsm_e;

  typedef struct packed {
    logic load;
    logic walk;
    logic decide;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic last_issue;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/arpc_ctrl.sv =====
// Sequencing state machine of the ARP cache engine.
// Uses arpc_pkg and the assertion macros header.
`default_nettype none
`include "arp_cache_engine_macros.svh"
module arpc_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  arpc_pkg::dp_stat_t    stat_i,
  output arpc_pkg::ctrl_cmd_t   cmd_o
);
  import arpc_pkg::*;

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) state_d = stat_i.need_walk ? FSM_SCAN : FSM_DECIDE;
      end
      FSM_SCAN: begin
        if (stat_i.last_issue) state_d = FSM_DRAIN;
      end
      FSM_DRAIN:  state_d = FSM_DECIDE;
      FSM_DECIDE: state_d = FSM_FINISH;
      FSM_FINISH: begin
        if (stat_i.out_free) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      FSM_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      FSM_SCAN:   cmd_o.walk   = 1'b1;
      FSM_DRAIN:  cmd_o.walk   = 1'b0;
      FSM_DECIDE: cmd_o.decide = 1'b1;
      FSM_FINISH: cmd_o.finish = stat_i.out_free;
      default:    cmd_o        = '0;
    endcase
  end

  `ARPC_ASSERT_NXT(a_load_leaves_idle, state_q == FSM_IDLE && in_valid_i, state_q != FSM_IDLE, "request accepted but controller stayed idle")
  `ARPC_ASSERT_NXT(a_drain_then_decide, state_q == FSM_DRAIN, state_q == FSM_DECIDE, "drain not followed by decision")
  `ARPC_ASSERT_NXT(a_finish_frees, state_q == FSM_FINISH && stat_i.out_free, state_q == FSM_IDLE, "result loaded but controller busy")

endmodule
`default_nettype wire

// ===== rtl/arpc_dp.sv =====
// Datapath of the ARP cache engine: config registers, entry stores, walk and result.
// Uses arpc_pkg; driven by arpc_ctrl commands.
`default_nettype none
`include "arp_cache_engine_macros.svh"
module arpc_dp #(
  parameter int unsigned ENTRIES = arpc_pkg::DefEntries
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire  [1:0]                          command_i,
  input  wire  [arpc_pkg::IpW-1:0]            ip_addr_i,
  input  wire  [arpc_pkg::MacW-1:0]           mac_addr_i,
  input  wire  [arpc_pkg::IpW-1:0]            arp_tpa_i,
  input  wire                                 is_request_i,
  input  wire                                 cfg_we_i,
  input  wire  [arpc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire  [arpc_pkg::IpW-1:0]            cfg_data_i,
  input  wire                                 out_stall_i,
  output logic                                out_valid_o,
  output logic [2:0]                          status_o,
  output logic [arpc_pkg::MacW-1:0]           mac_out_o,
  output logic [arpc_pkg::IpW-1:0]            next_hop_o,
  output logic                                reply_needed_o,
  output logic                                release_queued_o,
  output logic [arpc_pkg::ExpW-1:0]           expired_count_o,
  input  arpc_pkg::ctrl_cmd_t                 cmd_i,
  output arpc_pkg::dp_stat_t                  stat_o
);
  import arpc_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  logic [IpW-1:0]  my_ip_q, net_mask_q, my_net_q, gate_ip_q;
  logic [TtlW-1:0] pend_ttl_q, ent_ttl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_ip_q    <= '0;
      net_mask_q <= '0;
      my_net_q   <= '0;
      gate_ip_q  <= '0;
      pend_ttl_q <= PendTtlRst;
      ent_ttl_q  <= EntTtlRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MY_IP:       my_ip_q    <= cfg_data_i;
        CFG_NET_MASK:    net_mask_q <= cfg_data_i;
        CFG_MY_NET:      my_net_q   <= cfg_data_i;
        CFG_GATE_IP:     gate_ip_q  <= cfg_data_i;
        CFG_PENDING_TTL: pend_ttl_q <= cfg_data_i[TtlW-1:0];
        CFG_ENTRY_TTL:   ent_ttl_q  <= cfg_data_i[TtlW-1:0];
        default: ;
      endcase
    end
  end

  cmd_e           in_cmd;
  logic [IpW-1:0] in_hop;
  logic           need_walk;
  assign in_cmd = cmd_e'(command_i);

  always_comb begin
    in_hop = ip_addr_i;
    need_walk = 1'b1;
    case (in_cmd)
      CMD_RESOLVE: begin
        if (ip_addr_i == BcastIp) begin
          need_walk = 1'b0;
        end else if ((ip_addr_i & net_mask_q) != my_net_q) begin
          in_hop = gate_ip_q;
        end
      end
      CMD_TICK: in_hop = '0;
      default: begin
        if ((in_cmd == CMD_LEARN_ARP && arp_tpa_i != my_ip_q) || ip_addr_i == '0)
          need_walk = 1'b0;
      end
    endcase
  end

  cmd_e           cmd_q;
  logic [IpW-1:0] ip_q, tgt_q, hop_q;
  logic [MacW-1:0] mac_q;
  logic           req_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_cmd;
      ip_q  <= ip_addr_i;
      tgt_q <= arp_tpa_i;
      hop_q <= in_hop;
      mac_q <= mac_addr_i;
      req_q <= is_request_i;
    end
  end

  logic [IpW-1:0]  ip_mem  [ENTRIES];
  logic [TtlW-1:0] ttl_mem [ENTRIES];
  logic [MacW-1:0] mac_mem [ENTRIES];
  logic [ENTRIES-1:0] wr_q, pend_q, val_q;

  logic [IdxW-1:0] rd_idx_q, rd_at_q;
  logic            rd_v_q, rd_wr_q, rd_pend_q, rd_val_q;
  logic [IpW-1:0]  rd_ip_raw;
  logic [TtlW-1:0] rd_ttl_raw;
  logic [MacW-1:0] mac_rd_q;
  logic [IpW-1:0]  rd_ip;
  logic [TtlW-1:0] rd_ttl;

  logic            match_q, free_q;
  logic [IdxW-1:0] match_idx_q, free_idx_q, vic_idx_q;
  logic [TtlW-1:0] vic_ttl_q;
  logic [ExpW-1:0] exp_q;

  assign rd_ip  = rd_wr_q ? rd_ip_raw : '0;
  assign rd_ttl = rd_wr_q ? rd_ttl_raw : '0;

  logic            ip_we, ttl_we, mac_we, flag_we;
  logic [IdxW-1:0] w_idx;
  logic [IpW-1:0]  w_ip;
  logic [TtlW-1:0] w_ttl;
  logic            w_pend, w_val;
  logic            tick_free;
  logic [IdxW-1:0] alloc_idx;

  status_e  res_status;
  mac_sel_e res_sel;
  logic     res_reply, res_release;

  assign alloc_idx = free_q ? free_idx_q : vic_idx_q;

  always_comb begin
    ip_we = 1'b0; ttl_we = 1'b0; mac_we = 1'b0; flag_we = 1'b0;
    w_idx = rd_at_q; w_ip = '0; w_ttl = '0; w_pend = 1'b0; w_val = 1'b0;
    tick_free = 1'b0;
    res_status = ST_NOTUS; res_sel = MAC_ZERO; res_reply = 1'b0; res_release = 1'b0;
    if (rd_v_q && cmd_q == CMD_TICK && rd_ip != '0) begin
      if (rd_ttl != '0) begin
        ttl_we = 1'b1;
        w_ttl  = rd_ttl - 1'b1;
      end else begin
        ip_we     = 1'b1;
        ttl_we    = 1'b1;
        flag_we   = 1'b1;
        tick_free = 1'b1;
      end
    end
    case (cmd_q)
      CMD_RESOLVE: begin
        if (ip_q == BcastIp) begin
          res_status = ST_BCAST;
          res_sel    = MAC_ONES;
        end else if (match_q) begin
          if (pend_q[match_idx_q]) begin
            res_status = ST_PEND;
          end else begin
            res_status = ST_HIT;
            res_sel    = MAC_MEM;
          end
        end else begin
          res_status = ST_REQ;
          if (cmd_i.decide && hop_q != '0) begin
            ip_we = 1'b1; ttl_we = 1'b1; flag_we = 1'b1;
            w_idx = alloc_idx; w_ip = hop_q; w_ttl = pend_ttl_q; w_pend = 1'b1;
          end
        end
      end
      CMD_TICK: res_status = ST_TICKED;
      default: begin
        if (!(cmd_q == CMD_LEARN_ARP && tgt_q != my_ip_q)) begin
          res_reply = (cmd_q == CMD_LEARN_ARP) && req_q;
          if (ip_q != '0) begin
            if (match_q) begin
              res_status  = ST_UPD;
              res_release = pend_q[match_idx_q];
              if (cmd_i.decide) begin
                ttl_we = 1'b1; mac_we = 1'b1; flag_we = 1'b1;
                w_idx = match_idx_q; w_ttl = ent_ttl_q; w_val = 1'b1;
              end
            end else begin
              res_status = ST_INS;
              if (cmd_i.decide) begin
                ip_we = 1'b1; ttl_we = 1'b1; mac_we = 1'b1; flag_we = 1'b1;
                w_idx = alloc_idx; w_ip = ip_q; w_ttl = ent_ttl_q;
              end
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ip_we)  ip_mem[w_idx]  <= w_ip;
    if (ttl_we) ttl_mem[w_idx] <= w_ttl;
    if (mac_we) mac_mem[w_idx] <= mac_q;
    rd_ip_raw  <= ip_mem[rd_idx_q];
    rd_ttl_raw <= ttl_mem[rd_idx_q];
    mac_rd_q   <= mac_mem[match_idx_q];
    rd_at_q    <= rd_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= '0;
      pend_q    <= '0;
      val_q     <= '0;
      rd_idx_q  <= '0;
      rd_v_q    <= 1'b0;
      rd_wr_q   <= 1'b0;
      rd_pend_q <= 1'b0;
      rd_val_q  <= 1'b0;
    end else begin
      if (ip_we) wr_q[w_idx] <= 1'b1;
      if (flag_we) begin
        pend_q[w_idx] <= w_pend;
        val_q[w_idx]  <= w_val;
      end
      rd_v_q    <= cmd_i.walk;
      rd_wr_q   <= wr_q[rd_idx_q];
      rd_pend_q <= pend_q[rd_idx_q];
      rd_val_q  <= val_q[rd_idx_q];
      if (cmd_i.load) begin
        rd_idx_q <= '0;
      end else if (cmd_i.walk) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
      exp_q   <= '0;
    end else if (cmd_i.load) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
      exp_q   <= '0;
    end else if (rd_v_q) begin
      if (!match_q && hop_q != '0 && rd_ip == hop_q) begin
        match_q     <= 1'b1;
        match_idx_q <= rd_at_q;
      end
      if (!free_q && rd_ip == '0) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_at_q;
      end
      if (rd_at_q == '0) begin
        vic_idx_q <= '0;
        vic_ttl_q <= rd_ttl;
      end else if ((rd_pend_q || rd_val_q) && rd_ttl < vic_ttl_q) begin
        vic_idx_q <= rd_at_q;
        vic_ttl_q <= rd_ttl;
      end
      if (tick_free && exp_q != ExpMax) exp_q <= exp_q + 1'b1;
    end
  end

  status_e  res_status_q;
  mac_sel_e res_sel_q;
  logic     res_reply_q, res_release_q;
  logic     out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      res_status_q  <= res_status;
      res_sel_q     <= res_sel;
      res_reply_q   <= res_reply;
      res_release_q <= res_release;
    end
  end

  assign stat_o = '{
    need_walk:  need_walk,
    last_issue: (rd_idx_q == LastIdx),
    out_free:   (!out_valid_q || !out_stall_i)
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_o         <= res_status_q;
      next_hop_o       <= hop_q;
      reply_needed_o   <= res_reply_q;
      release_queued_o <= res_release_q;
      expired_count_o  <= exp_q;
      case (res_sel_q)
        MAC_ONES: mac_out_o <= '1;
        MAC_MEM:  mac_out_o <= mac_rd_q;
        default:  mac_out_o <= '0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `ARPC_ASSERT_NOW(a_no_double_write, rd_v_q && cmd_q == CMD_TICK, !cmd_i.decide, "tick write collides with decision write")
  `ARPC_ASSERT_NXT(a_free_sets_written, ip_we, wr_q[$past(w_idx)], "written entry not marked")
  `ARPC_ASSERT_NXT(a_out_held, out_valid_q && out_stall_i, out_valid_q && $stable(status_o), "stalled result changed")

endmodule
`default_nettype wire

// ===== rtl/arp_cache_engine.sv =====
// ARP cache engine top level: controller plus datapath.
// Uses arpc_pkg, arpc_ctrl and arpc_dp.
//
// Requests enter on in_valid_i/in_stall_o carrying command_i, ip_addr_i,
// mac_addr_i, arp_tpa_i and is_request_i; one result per request leaves on
// out_valid_o/out_stall_i. Registers are written on cfg_valid_i/cfg_ready_o,
// cfg_ready_o is always high; write them only while the block is idle.
// Resolve, learn and tick walk every cache entry once, one entry per cycle
// through the entry store read port, then drain the read register and decide
// before the result register is loaded. Broadcast resolves, learns not for
// this host and learns with a zero sender skip the walk and go to the decision.
// One request is in flight at a time; the next is accepted the cycle after
// the result is loaded, even while that result still waits downstream.
// A stalled result holds in the output register; a finished request waits
// for the register to free before it is loaded.
// Reset empties the cache at once (per-entry written bits) and loads
// pending_ttl 20 and entry_ttl 1200; other registers reset to zero.
`default_nettype none
module arp_cache_engine #(
  parameter int unsigned ENTRIES = arpc_pkg::DefEntries
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [1:0]                       command_i,
  input  wire  [arpc_pkg::IpW-1:0]         ip_addr_i,
  input  wire  [arpc_pkg::MacW-1:0]        mac_addr_i,
  input  wire  [arpc_pkg::IpW-1:0]         arp_tpa_i,
  input  wire                              is_request_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [2:0]                       status_o,
  output logic [arpc_pkg::MacW-1:0]        mac_out_o,
  output logic [arpc_pkg::IpW-1:0]         next_hop_o,
  output logic                             reply_needed_o,
  output logic                             release_queued_o,
  output logic [arpc_pkg::ExpW-1:0]        expired_count_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [arpc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [arpc_pkg::IpW-1:0]         cfg_data_i
);
  import arpc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  arpc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .command_i        (command_i),
    .ip_addr_i        (ip_addr_i),
    .mac_addr_i       (mac_addr_i),
    .arp_tpa_i        (arp_tpa_i),
    .is_request_i     (is_request_i),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .mac_out_o        (mac_out_o),
    .next_hop_o       (next_hop_o),
    .reply_needed_o   (reply_needed_o),
    .release_queued_o (release_queued_o),
    .expired_count_o  (expired_count_o),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the ARP cache engine: resolve, learn and tick
// requests with an internal cache predictor, random idling and stalls.
// Depends on arpc_pkg and the arp_cache_engine RTL.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import arpc_pkg::*;

  localparam int NE = 32;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    cmd_e             cmd;
    logic [IpW-1:0]   ip;
    logic [MacW-1:0]  mac;
    logic [IpW-1:0]   tgt;
    logic             is_req;
  } req_t;

  typedef struct packed {
    status_e          st;
    logic [MacW-1:0]  mac;
    logic [IpW-1:0]   hop;
    logic             reply;
    logic             release_q;
    logic [ExpW-1:0]  expired;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = '0;
  logic [IpW-1:0] ip_addr = '0;
  logic [MacW-1:0] mac_addr = '0;
  logic [IpW-1:0] arp_tpa = '0;
  logic is_request = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [MacW-1:0] mac_out;
  logic [IpW-1:0] next_hop;
  logic reply_needed, release_queued;
  logic [ExpW-1:0] expired_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [IpW-1:0] cfg_data = '0;

  arp_cache_engine dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .ip_addr_i(ip_addr), .mac_addr_i(mac_addr),
    .arp_tpa_i(arp_tpa), .is_request_i(is_request),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .mac_out_o(mac_out), .next_hop_o(next_hop),
    .reply_needed_o(reply_needed), .release_queued_o(release_queued),
    .expired_count_o(expired_count),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [IpW-1:0]  c_my_ip, c_mask, c_net, c_gate;
  logic [TtlW-1:0] c_pend_ttl, c_ent_ttl;
  logic [IpW-1:0]  tbl_ip [NE];
  logic [MacW-1:0] tbl_mac [NE];
  logic [TtlW-1:0] tbl_ttl [NE];
  logic            tbl_pend [NE];
  logic            tbl_valid [NE];

  req_t pending_reqs[$];
  res_t expected_results[$];
  int mismatches = 0;
  int n_results = 0;
  int n_hits = 0;
  int n_expired = 0;
  int sent = 0;
  int idle_cycles = 0;
  bit hold_on = 1'b0;
  int hold_left = 0;
  logic accepted_q = 1'b0;
  logic out_valid_q = 1'b0;

  function automatic int lookup(logic [IpW-1:0] a);
    if (a == '0) return -1;
    for (int i = 0; i < NE; i++) if (tbl_ip[i] == a) return i;
    return -1;
  endfunction

  function automatic int pick_slot();
    int v;
    v = 0;
    for (int i = 0; i < NE; i++) if (tbl_ip[i] == '0) return i;
    for (int i = 0; i < NE; i++)
      if ((tbl_pend[i] || tbl_valid[i]) && tbl_ttl[i] < tbl_ttl[v]) v = i;
    return v;
  endfunction

  function automatic res_t predict_cache(req_t r);
    res_t o;
    int e;
    o = '{st: ST_HIT, mac: '0, hop: '0, reply: 1'b0, release_q: 1'b0, expired: '0};
    case (r.cmd)
      CMD_RESOLVE: begin
        if (r.ip == BcastIp) begin
          o.st = ST_BCAST;
          o.mac = '1;
          o.hop = r.ip;
        end else begin
          o.hop = ((r.ip & c_mask) != c_net) ? c_gate : r.ip;
          e = lookup(o.hop);
          if (e >= 0) begin
            if (tbl_pend[e]) o.st = ST_PEND;
            else begin
              o.st = ST_HIT;
              o.mac = tbl_mac[e];
            end
          end else begin
            o.st = ST_REQ;
            if (o.hop != '0) begin
              e = pick_slot();
              tbl_ip[e] = o.hop;
              tbl_pend[e] = 1'b1;
              tbl_valid[e] = 1'b0;
              tbl_ttl[e] = c_pend_ttl;
            end
          end
        end
      end
      CMD_TICK: begin
        o.st = ST_TICKED;
        for (int i = 0; i < NE; i++) begin
          if (tbl_ip[i] != '0) begin
            if (tbl_ttl[i] != '0) tbl_ttl[i] = tbl_ttl[i] - 1'b1;
            else begin
              tbl_ip[i] = '0;
              tbl_pend[i] = 1'b0;
              tbl_valid[i] = 1'b0;
              if (o.expired != ExpMax) o.expired = o.expired + 1'b1;
            end
          end
        end
      end
      default: begin
        o.hop = r.ip;
        if (r.cmd == CMD_LEARN_ARP && r.tgt != c_my_ip) o.st = ST_NOTUS;
        else begin
          o.reply = (r.cmd == CMD_LEARN_ARP) && r.is_req;
          if (r.ip == '0) o.st = ST_NOTUS;
          else begin
            e = lookup(r.ip);
            if (e >= 0) begin
              tbl_mac[e] = r.mac;
              tbl_ttl[e] = c_ent_ttl;
              tbl_valid[e] = 1'b1;
              if (tbl_pend[e]) begin
                tbl_pend[e] = 1'b0;
                o.release_q = 1'b1;
              end
              o.st = ST_UPD;
            end else begin
              e = pick_slot();
              tbl_ip[e] = r.ip;
              tbl_mac[e] = r.mac;
              tbl_pend[e] = 1'b0;
              tbl_valid[e] = 1'b0;
              tbl_ttl[e] = c_ent_ttl;
              o.st = ST_INS;
            end
          end
        end
      end
    endcase
    return o;
  endfunction

  // acceptance seen at the rising edge
  always @(posedge clk) begin
    accepted_q <= in_valid && !in_stall;
  end

  // driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || accepted_q) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          command <= r.cmd;
          ip_addr <= r.ip;
          mac_addr <= r.mac;
          arp_tpa <= r.tgt;
          is_request <= r.is_req;
          in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
          expected_results.push_back(predict_cache(r));
          sent <= sent + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_on) begin
        hold_on <= 1'b0;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid_q) out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_valid_q <= out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      res_t exp_r;
      n_results <= n_results + 1;
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result, status %0d", status);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.st == ST_HIT) n_hits <= n_hits + 1;
        n_expired <= n_expired + exp_r.expired;
        if (status != exp_r.st || mac_out != exp_r.mac || next_hop != exp_r.hop ||
            reply_needed != exp_r.reply || release_queued != exp_r.release_q ||
            expired_count != exp_r.expired) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp st=%0d mac=%h hop=%h rep=%b rel=%b exp=%0d | got st=%0d mac=%h hop=%h rep=%b rel=%b exp=%0d",
              exp_r.st, exp_r.mac, exp_r.hop, exp_r.reply, exp_r.release_q, exp_r.expired,
              status, mac_out, next_hop, reply_needed, release_queued, expired_count);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid ||
        (pending_reqs.size() == 0 && expected_results.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired");
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_e idx, logic [IpW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MY_IP:       c_my_ip = val;
      CFG_NET_MASK:    c_mask = val;
      CFG_MY_NET:      c_net = val;
      CFG_GATE_IP:     c_gate = val;
      CFG_PENDING_TTL: c_pend_ttl = val[TtlW-1:0];
      CFG_ENTRY_TTL:   c_ent_ttl = val[TtlW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic req_t mk(cmd_e c, logic [IpW-1:0] ip, logic [MacW-1:0] m,
                              logic [IpW-1:0] t, logic q);
    req_t r;
    r.cmd = c; r.ip = ip; r.mac = m; r.tgt = t; r.is_req = q;
    return r;
  endfunction

  // address drawn mostly from a small on-net pool so hits and refreshes occur
  function automatic logic [IpW-1:0] pick_ip();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? BcastIp : '0;
      2: return c_gate;
      default: return (c_net & c_mask) | (IpW'($urandom_range(1, 40)) & ~c_mask);
    endcase
  endfunction

  function automatic req_t rand_req();
    int k;
    logic [IpW-1:0] t;
    logic [MacW-1:0] m;
    logic q;
    k = $urandom_range(0, 99);
    t = ($urandom_range(0, 4) == 0) ? $urandom() : c_my_ip;
    m = MacW'({$urandom(), $urandom()});
    q = 1'($urandom_range(0, 1));
    if (k < 35) return mk(CMD_RESOLVE, pick_ip(), m, $urandom(), q);
    if (k < 60) return mk(CMD_LEARN_ARP, pick_ip(), m, t, q);
    if (k < 80) return mk(CMD_LEARN_DIRECT, pick_ip(), m, $urandom(), q);
    return mk(CMD_TICK, $urandom(), m, $urandom(), q);
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
    drain();
  endtask

  initial begin
    c_my_ip = '0; c_mask = '0; c_net = '0; c_gate = '0;
    c_pend_ttl = PendTtlRst; c_ent_ttl = EntTtlRst;
    for (int i = 0; i < NE; i++) begin
      tbl_ip[i] = '0; tbl_mac[i] = '0; tbl_ttl[i] = '0;
      tbl_pend[i] = 1'b0; tbl_valid[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: everything on-net, gateway zero
    pending_reqs.push_back(mk(CMD_RESOLVE, BcastIp, '0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_RESOLVE, '0, '0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_LEARN_DIRECT, '0, '1, '0, 1'b0));
    drain();

    write_reg(CFG_MY_IP, 32'h0a00_0001);
    write_reg(CFG_NET_MASK, 32'hffff_ff00);
    write_reg(CFG_MY_NET, 32'h0a00_0000);
    write_reg(CFG_GATE_IP, 32'h0a00_00fe);
    write_reg(CFG_PENDING_TTL, 32'd2);
    write_reg(CFG_ENTRY_TTL, 32'd3);

    pending_reqs.push_back(mk(CMD_RESOLVE, 32'h0a00_0005, '0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_RESOLVE, 32'h0a00_0005, '0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_LEARN_ARP, 32'h0a00_0005, '1, 32'h0a00_0001, 1'b1));
    pending_reqs.push_back(mk(CMD_RESOLVE, 32'h0a00_0005, '0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_LEARN_ARP, 32'h0a00_0006, 48'h0, 32'h0b00_0001, 1'b1));
    pending_reqs.push_back(mk(CMD_LEARN_ARP, 32'h0, 48'h1, 32'h0a00_0001, 1'b1));
    pending_reqs.push_back(mk(CMD_LEARN_DIRECT, 32'h0a00_0007, 48'haaaa_5555_aaaa, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_LEARN_DIRECT, 32'h0a00_0007, 48'h5555_aaaa_5555, '1, 1'b1));
    pending_reqs.push_back(mk(CMD_RESOLVE, 32'hc0a8_0101, '0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_LEARN_DIRECT, 32'h0a00_00fe, 48'h1234_5678_9abc, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_RESOLVE, 32'h0808_0808, '0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_RESOLVE, 32'h7fff_ffff, '0, '0, 1'b1));
    for (int i = 0; i < 6; i++) pending_reqs.push_back(mk(CMD_TICK, '0, '0, '0, 1'b0));
    drain();

    // fill the cache past capacity to exercise eviction
    for (int i = 1; i <= 40; i++)
      pending_reqs.push_back(mk(i % 2 ? CMD_RESOLVE : CMD_LEARN_DIRECT,
                                32'h0a00_0000 | IpW'(i), MacW'({$urandom(), $urandom()}),
                                '0, 1'b0));
    hold_on <= 1'b1;
    drain();
    run_random(380);

    write_reg(CFG_PENDING_TTL, 32'h7ff);
    write_reg(CFG_ENTRY_TTL, 32'h0);
    write_reg(CFG_MY_IP, 32'hffff_ffff);
    write_reg(CFG_NET_MASK, 32'h0);
    write_reg(CFG_MY_NET, 32'h0);
    write_reg(CFG_GATE_IP, 32'hffff_ffff);
    run_random(280);

    write_reg(CFG_NET_MASK, 32'hffff_ffff);
    write_reg(CFG_MY_NET, $urandom());
    write_reg(CFG_GATE_IP, $urandom());
    write_reg(CFG_MY_IP, $urandom());
    write_reg(CFG_PENDING_TTL, 32'd0);
    write_reg(CFG_ENTRY_TTL, 32'h7ff);
    run_random(250);

    write_reg(CFG_MY_IP, 32'hc0a8_0001);
    write_reg(CFG_NET_MASK, 32'hffff_ffc0);
    write_reg(CFG_MY_NET, 32'hc0a8_0000);
    write_reg(CFG_GATE_IP, 32'h0);
    write_reg(CFG_PENDING_TTL, 32'd5);
    write_reg(CFG_ENTRY_TTL, 32'd9);
    run_random(300);

    $display("covered %0d requests, %0d results, %0d hits, %0d entries aged out",
             sent, n_results, n_hits, n_expired);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
